FILE: rtl/core/cle_pkg.sv
`timescale 1ns / 1ps
// cle_pkg: shared types and constants for the cubic lower envelope tree.
// Used by cle_eval, cle_dp, cle_ctrl and cubic_lower_envelope_tree. No dependencies.
package cle_pkg;

  localparam logic [63:0] BIG_VALUE = 64'd1000000000000000000;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    EV_T_LO,
    EV_P_LO,
    EV_T_MID,
    EV_P_MID,
    EV_T_Q
  } ev_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SM_RUN,
    ST_SM_DRAIN,
    ST_TR_READ,
    ST_EV_GO,
    ST_EV_WAIT,
    ST_TI_WRITE,
    ST_TQ_STEP,
    ST_SQ_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic    load_item;
    logic    small_init;
    logic    small_step;
    logic    small_rd_q;
    logic    tree_init;
    logic    tree_rd;
    logic    ev_start;
    logic    ev_cap;
    ev_sel_t ev_sel;
    logic    ti_write;
    logic    tq_step;
    logic    out_load;
    logic    clr_step;
  } cle_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       q_small;
    logic       tree_en;
    logic       small_last;
    logic       tree_last;
    logic       ev_done;
    logic       clr_last;
    logic       out_free;
  } cle_stat_t;

endpackage

FILE: rtl/core/cle_eval.sv
`timescale 1ns / 1ps
// cle_eval: multicycle Horner evaluator of a cubic, 64-bit wrapping.
// Uses cle_pkg. One 32-bit-wide multiply per cycle.
module cle_eval import cle_pkg::*; #(
  parameter int XW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  input  logic [63:0]   c,
  input  logic [63:0]   d,
  input  logic [XW-1:0] x,
  output logic          done,
  output logic [63:0]   value
);

  logic        busy;
  logic        ph;
  logic [1:0]  step;
  logic [63:0] acc;
  logic [63:0] p0;
  logic [31:0] x_r;
  logic [63:0] b_r, c_r, d_r;
  logic [63:0] addend;
  logic [63:0] hi_prod;
  logic [63:0] sum;

  always_comb begin
    unique case (step)
      2'd0:    addend = b_r;
      2'd1:    addend = c_r;
      default: addend = d_r;
    endcase
  end

  assign hi_prod = 64'(acc[63:32]) * 64'(x_r);
  assign sum     = {hi_prod[31:0], 32'b0} + p0 + addend;
  assign value   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ph   <= 1'b0;
        step <= 2'd0;
      end else if (busy) begin
        ph <= ~ph;
        if (ph) begin
          if (step == 2'd2) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            step <= step + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= a;
      b_r <= b;
      c_r <= c;
      d_r <= d;
      x_r <= 32'(x);
    end else if (busy) begin
      if (!ph) begin
        p0 <= 64'(acc[31:0]) * 64'(x_r);
      end else begin
        acc <= sum;
      end
    end
  end

endmodule

FILE: rtl/core/cle_dp.sv
`timescale 1ns / 1ps
// cle_dp: datapath with the small-x minima memory, the node memory and the tree walk.
// Uses cle_pkg and cle_eval.
module cle_dp import cle_pkg::*; #(
  parameter int SMALL_LIMIT = 350,
  parameter int X_MAX       = 131071,
  parameter int TREE_NODES  = 262144
) (
  input  logic               clk,
  input  logic               rst,
  input  cle_cmd_t           cmd,
  output cle_stat_t          stat,
  input  logic [1:0]         op,
  input  logic signed [63:0] coef_a,
  input  logic signed [63:0] coef_b,
  input  logic signed [63:0] coef_c,
  input  logic signed [63:0] coef_d,
  input  logic [16:0]        query_x,
  input  logic               result_stall,
  output logic               result_valid,
  output logic signed [63:0] min_value
);

  localparam int QXW  = 17;
  localparam int XW_A = $clog2(X_MAX + 1);
  localparam int XW_B = $clog2(SMALL_LIMIT + 2);
  localparam int XW_C = (XW_A > XW_B) ? XW_A : XW_B;
  localparam int XW   = (XW_C > QXW) ? XW_C : QXW;
  localparam int SW   = (SMALL_LIMIT > 0) ? $clog2(SMALL_LIMIT + 1) : 1;
  localparam int SDEP = SMALL_LIMIT + 1;
  localparam int TW   = $clog2(TREE_NODES);
  localparam int CN   = (TREE_NODES > SDEP) ? TREE_NODES : SDEP;
  localparam int CW   = $clog2(CN);
  localparam bit TREE_EN = (SMALL_LIMIT + 1) <= X_MAX;

  logic [63:0]   small_mem [SDEP];
  logic [255:0]  tree_mem  [TREE_NODES];

  logic [1:0]    op_r;
  logic [XW-1:0] xq;
  logic [63:0]   pa, pb, pc, pd;
  logic [255:0]  tr_q;
  logic [63:0]   sm_q;

  logic [63:0]   f0, f1, f2, f3;
  logic [SW-1:0] j;
  logic          s1_v;
  logic [SW-1:0] s1_j;
  logic [63:0]   s1_val;

  logic [TW-1:0] node;
  logic [XW-1:0] lo, hi;
  logic [XW:0]   lo_hi_sum;
  logic [XW-1:0] mid;
  logic          at_lo, at_mid;
  logic [63:0]   v_hold;
  logic [63:0]   best;
  logic          first;
  logic          res_small;
  logic [CW-1:0] clr_cnt;

  logic          go_right;
  logic [TW:0]   next_node;
  logic          is_insert;

  logic [63:0]   ta, tb, tc, td;
  logic [63:0]   ea, eb, ec, ed;
  logic [XW-1:0] ex;
  logic          ev_done;
  logic [63:0]   ev_val;
  logic [SW-1:0] sm_addr;
  logic [63:0]   six_a;

  assign {ta, tb, tc, td} = tr_q;
  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = lo_hi_sum[XW:1];
  assign is_insert = (op_r == OP_INSERT);
  assign go_right  = is_insert ? (at_lo == at_mid) : !(mid >= xq);
  assign next_node = {node, go_right};
  assign six_a     = (pa << 2) + (pa << 1);

  always_comb begin
    stat.op         = op_r;
    stat.q_small    = (xq <= XW'(SMALL_LIMIT));
    stat.tree_en    = TREE_EN;
    stat.small_last = (j == SW'(SMALL_LIMIT));
    stat.tree_last  = (lo == hi) || (next_node >= (TW + 1)'(TREE_NODES));
    stat.ev_done    = ev_done;
    stat.clr_last   = (clr_cnt == CW'(CN - 1));
    stat.out_free   = !result_valid || !result_stall;
  end

  // evaluator operands
  always_comb begin
    unique case (cmd.ev_sel)
      EV_P_LO, EV_P_MID: {ea, eb, ec, ed} = {pa, pb, pc, pd};
      default:           {ea, eb, ec, ed} = {ta, tb, tc, td};
    endcase
    unique case (cmd.ev_sel)
      EV_T_LO, EV_P_LO:   ex = lo;
      EV_T_MID, EV_P_MID: ex = mid;
      default:            ex = xq;
    endcase
  end

  cle_eval #(.XW(XW)) u_eval (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.ev_start),
    .a     (ea),
    .b     (eb),
    .c     (ec),
    .d     (ed),
    .x     (ex),
    .done  (ev_done),
    .value (ev_val)
  );

  assign sm_addr = cmd.small_step ? j : xq[SW-1:0];

  // small-x minima memory
  always_ff @(posedge clk) begin
    if (cmd.small_step || cmd.small_rd_q) begin
      sm_q <= small_mem[sm_addr];
    end
    if (cmd.clr_step) begin
      if (clr_cnt <= CW'(SMALL_LIMIT)) begin
        small_mem[clr_cnt[SW-1:0]] <= BIG_VALUE;
      end
    end else if (s1_v && ($signed(sm_q) > $signed(s1_val))) begin
      small_mem[s1_j] <= s1_val;
    end
  end

  // node memory: {a, b, c, d}
  always_ff @(posedge clk) begin
    if (cmd.tree_rd) begin
      tr_q <= tree_mem[node];
    end
    if (cmd.clr_step) begin
      if ({1'b0, clr_cnt} < (CW + 1)'(TREE_NODES)) begin
        tree_mem[clr_cnt[TW-1:0]] <= {64'd0, 64'd0, 64'd0, BIG_VALUE};
      end
    end else if (cmd.ti_write) begin
      tree_mem[node] <= at_mid ? {pa, pb, pc, pd} : tr_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      s1_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_v <= cmd.small_step;
      if (cmd.clr_step) begin
        clr_cnt <= stat.clr_last ? '0 : clr_cnt + CW'(1);
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= op;
      pa   <= coef_a;
      pb   <= coef_b;
      pc   <= coef_c;
      pd   <= coef_d;
      xq   <= XW'(query_x);
    end
    // forward differences over x = 0 .. SMALL_LIMIT
    if (cmd.small_init) begin
      f0 <= pd;
      f1 <= pa + pb + pc;
      f2 <= six_a + (pb << 1);
      f3 <= six_a;
      j  <= '0;
    end else if (cmd.small_step) begin
      f0 <= f0 + f1;
      f1 <= f1 + f2;
      f2 <= f2 + f3;
      j  <= j + SW'(1);
    end
    s1_j   <= j;
    s1_val <= f0;

    if (cmd.tree_init) begin
      node      <= TW'(1);
      lo        <= XW'(SMALL_LIMIT + 1);
      hi        <= XW'(X_MAX);
      best      <= BIG_VALUE;
      first     <= 1'b1;
      res_small <= (xq <= XW'(SMALL_LIMIT));
    end
    if (cmd.ev_cap) begin
      unique case (cmd.ev_sel)
        EV_T_LO, EV_T_MID: v_hold <= ev_val;
        EV_P_LO:           at_lo  <= $signed(v_hold) > $signed(ev_val);
        EV_P_MID:          at_mid <= $signed(v_hold) > $signed(ev_val);
        default: begin
          if (first || ($signed(best) > $signed(ev_val))) begin
            best <= ev_val;
          end
          first <= 1'b0;
        end
      endcase
    end
    if (cmd.ti_write && at_mid) begin
      {pa, pb, pc, pd} <= tr_q;
    end
    if ((cmd.ti_write || cmd.tq_step) && !stat.tree_last) begin
      node <= next_node[TW-1:0];
      if (go_right) begin
        lo <= mid + XW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.out_load) begin
      min_value <= res_small ? sm_q : best;
    end
  end

endmodule

FILE: rtl/core/cle_ctrl.sv
`timescale 1ns / 1ps
// cle_ctrl: sequencer for insert, query and clear words.
// Uses cle_pkg; drives cle_dp through cle_cmd_t.
module cle_ctrl import cle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  cle_stat_t stat,
  output cle_cmd_t  cmd
);

  state_t  state, state_next;
  ev_sel_t ev_sel, ev_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      ev_sel <= EV_T_LO;
    end else begin
      state  <= state_next;
      ev_sel <= ev_sel_next;
    end
  end

  always_comb begin
    state_next  = state;
    ev_sel_next = ev_sel;
    cmd         = '0;
    cmd.ev_sel  = ev_sel;
    item_stall  = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.tree_init = 1'b1;
        unique case (stat.op)
          OP_INSERT: begin
            cmd.small_init = 1'b1;
            state_next     = ST_SM_RUN;
          end
          OP_QUERY: begin
            if (stat.q_small)      state_next = ST_SQ_READ;
            else if (stat.tree_en) state_next = ST_TR_READ;
            else                   state_next = ST_OUT;
          end
          OP_CLEAR: state_next = ST_CLEAR;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_SM_RUN: begin
        cmd.small_step = 1'b1;
        if (stat.small_last) state_next = ST_SM_DRAIN;
      end
      ST_SM_DRAIN: begin
        state_next = stat.tree_en ? ST_TR_READ : ST_IDLE;
      end
      ST_TR_READ: begin
        cmd.tree_rd = 1'b1;
        ev_sel_next = (stat.op == OP_QUERY) ? EV_T_Q : EV_T_LO;
        state_next  = ST_EV_GO;
      end
      ST_EV_GO: begin
        cmd.ev_start = 1'b1;
        state_next   = ST_EV_WAIT;
      end
      ST_EV_WAIT: begin
        if (stat.ev_done) begin
          cmd.ev_cap = 1'b1;
          unique case (ev_sel)
            EV_T_LO: begin
              ev_sel_next = EV_P_LO;
              state_next  = ST_EV_GO;
            end
            EV_P_LO: begin
              ev_sel_next = EV_T_MID;
              state_next  = ST_EV_GO;
            end
            EV_T_MID: begin
              ev_sel_next = EV_P_MID;
              state_next  = ST_EV_GO;
            end
            EV_P_MID: state_next = ST_TI_WRITE;
            default:  state_next = ST_TQ_STEP;
          endcase
        end
      end
      ST_TI_WRITE: begin
        cmd.ti_write = 1'b1;
        state_next   = stat.tree_last ? ST_IDLE : ST_TR_READ;
      end
      ST_TQ_STEP: begin
        cmd.tq_step = 1'b1;
        state_next  = stat.tree_last ? ST_OUT : ST_TR_READ;
      end
      ST_SQ_READ: begin
        cmd.small_rd_q = 1'b1;
        state_next     = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/cubic_lower_envelope_tree.sv
`timescale 1ns / 1ps
// cubic_lower_envelope_tree: lower envelope of cubics, small-x table plus Li Chao tree.
// Uses cle_pkg, cle_ctrl, cle_dp (which holds cle_eval).
//
// Input channel (item_valid / item_stall): one word per item. op 0 inserts the
// cubic coef_a..coef_d, op 1 asks the minimum at query_x, op 2 clears both stores,
// op 3 is dropped. Output channel (result_valid / result_stall): one min_value
// word per query, nothing for other ops.
// Sequence per op (tree depth about log2(X_MAX - SMALL_LIMIT) + 1, 18 at defaults):
//   insert: forward-difference table update (one entry a cycle through the
//           table's read/write ports), then, if the tree is enabled, per tree
//           level: node read, four 64-bit cubic evaluations on one Horner unit,
//           write-back.
//   query : x <= SMALL_LIMIT: one small-table read; otherwise one evaluation per level.
//   clear : resets every entry of both memories, one entry of each memory per cycle.
// One item is worked at a time; item_stall is low only while idle.
// Reset runs the same clearing pass, with item_stall high until it ends.
// A finished query result sits in the output register; while result_stall holds
// it, the block stays idle-ready for new items, and a later query waits to load.
module cubic_lower_envelope_tree import cle_pkg::*; #(
  parameter int SMALL_LIMIT = 350,
  parameter int X_MAX       = 131071,
  parameter int TREE_NODES  = 262144
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         op,
  input  logic signed [63:0] coef_a,
  input  logic signed [63:0] coef_b,
  input  logic signed [63:0] coef_c,
  input  logic signed [63:0] coef_d,
  input  logic [16:0]        query_x,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [63:0] min_value
);

  cle_cmd_t  cmd;
  cle_stat_t stat;

  cle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  cle_dp #(
    .SMALL_LIMIT (SMALL_LIMIT),
    .X_MAX       (X_MAX),
    .TREE_NODES  (TREE_NODES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .coef_c       (coef_c),
    .coef_d       (coef_d),
    .query_x      (query_x),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .min_value    (min_value)
  );

endmodule
